// ----- design/ate_pkg.sv -----
package ate_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CMD_W = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int ST_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 4'd0,
        CMD_APPEND  = 4'd1,
        CMD_READ    = 4'd2,
        CMD_PERFECT = 4'd3,
        CMD_SECOND  = 4'd4,
        CMD_INSERT  = 4'd5,
        CMD_DELETE  = 4'd6,
        CMD_SEARCH  = 4'd7,
        CMD_PART    = 4'd8,
        CMD_REVERSE = 4'd9
    } t_cmd;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] result_value;
        logic                    found;
        logic [POS_W-1:0]        length;
    } t_out;

    function automatic logic is_perfect(input logic signed [VAL_W-1:0] x);
        return (x == 32'sd6) || (x == 32'sd28) || (x == 32'sd496) ||
               (x == 32'sd8128) || (x == 32'sd33550336);
    endfunction

endpackage

// ----- design/array_table_engine.sv -----
// Command engine over a table of up to DEPTH signed 32-bit elements. Pulse
// i_start with a command while o_busy is low; exactly one result beat follows
// on o_result, marked by o_done for one cycle, which the receiver must take
// then. Clear answers at once, append makes one write and read one read;
// search makes one read per halving step; scans read each element once,
// insert and delete read and write each element moved; partition scans
// twice into a scratch table and copies it back; reverse swaps pairs. The
// table memory has registered read data, one read and one write port.
module array_table_engine
    import ate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_cmd,
    output logic o_busy,
    output logic o_done,
    output t_out o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_USE   = 9'b000001000,
        S_WR    = 9'b000010000,
        S_P2    = 9'b000100000,
        S_COPY  = 9'b001000000,
        S_CWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_scr [DEPTH];
    logic [VAL_W-1:0] r_rdata, r_sdata;

    t_state r_state;
    t_cmd   r_cmd;
    logic signed [VAL_W-1:0] r_val, r_a, r_b, r_res;
    logic [CW-1:0] r_cnt, r_i, r_j, r_w;
    logic signed [CW:0] r_lo, r_hi;
    logic [ST_W-1:0] r_st;
    logic r_found, r_pass, r_half;

    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [VAL_W-1:0] mem_wd;
    logic scr_we;
    logic signed [CW+1:0] lh_sum;
    logic signed [CW:0] mid;
    logic signed [VAL_W-1:0] x;
    logic [PW-1:0] pos_ext, cnt_ext;

    assign x = r_rdata;
    assign lh_sum = {r_lo[CW], r_lo} + {r_hi[CW], r_hi};
    assign mid = lh_sum[CW+1:1];
    assign pos_ext = PW'(i_cmd.position);
    assign cnt_ext = PW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
        if (scr_we) begin
            r_scr[r_w[AW-1:0]] <= r_rdata;
        end
        r_sdata <= r_scr[r_i[AW-1:0]];
    end

    // read address and write port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_i[AW-1:0];
        mem_wd = r_val;
        mem_ra = r_i[AW-1:0];
        scr_we = 1'b0;
        if (r_cmd == CMD_SEARCH) mem_ra = mid[AW-1:0];
        if (r_cmd == CMD_REVERSE && r_half) mem_ra = r_j[AW-1:0];
        unique case (r_state)
            S_WR: begin
                mem_we = 1'b1;
                unique case (r_cmd)
                    CMD_APPEND: begin mem_wa = r_cnt[AW-1:0]; mem_wd = r_val; end
                    CMD_INSERT, CMD_DELETE: begin
                        mem_wa = r_i[AW-1:0]; mem_wd = r_a;
                    end
                    CMD_REVERSE: begin
                        mem_wa = r_half ? r_i[AW-1:0] : r_j[AW-1:0];
                        mem_wd = r_half ? r_b : r_a;
                    end
                    default: mem_we = 1'b0;
                endcase
            end
            S_USE: scr_we = (r_cmd == CMD_PART) && (x[0] == r_pass);
            S_COPY: begin mem_we = 1'b1; mem_wd = r_sdata; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_cmd <= t_cmd'(i_cmd.command);
                    r_val <= i_cmd.value;
                    r_st <= ST_OK;
                    // second largest of an empty table stays at its start value
                    r_res <= (i_cmd.command == CMD_SECOND) ? -32'sd1 : 32'sd0;
                    r_found <= 1'b0;
                    r_pass <= 1'b0;
                    r_half <= 1'b0;
                    r_w <= '0;
                    r_i <= '0;
                    r_a <= -32'sd1;
                    r_b <= -32'sd1;
                    r_lo <= '0;
                    r_hi <= (CW+1)'($signed({1'b0, r_cnt}) - 1);
                    r_state <= S_DONE;
                    case (i_cmd.command)
                        CMD_CLEAR: r_cnt <= '0;
                        CMD_APPEND:
                            if (r_cnt >= CW'(DEPTH)) r_st <= ST_FULL;
                            else r_state <= S_WR;
                        CMD_READ:
                            if (pos_ext >= cnt_ext)
                                r_st <= ST_RANGE;
                            else begin
                                r_i <= CW'(i_cmd.position);
                                r_state <= S_RD;
                            end
                        CMD_PERFECT, CMD_SECOND, CMD_PART:
                            if (r_cnt != '0) r_state <= S_RD;
                        CMD_SEARCH: r_state <= S_RD;
                        CMD_INSERT:
                            if (pos_ext > cnt_ext)
                                r_st <= ST_RANGE;
                            else if (r_cnt >= CW'(DEPTH)) r_st <= ST_FULL;
                            else begin
                                r_j <= CW'(i_cmd.position);
                                r_i <= r_cnt;
                                r_state <= S_RD;
                            end
                        CMD_DELETE:
                            if (pos_ext >= cnt_ext)
                                r_st <= ST_RANGE;
                            else begin
                                r_i <= CW'(i_cmd.position);
                                r_state <= S_RD;
                            end
                        CMD_REVERSE:
                            if (r_cnt > CW'(1)) begin
                                r_j <= r_cnt - 1'b1;
                                r_state <= S_RD;
                            end
                        default: ;
                    endcase
                end
                S_RD: begin
                    // insert moves down from the top; stop at the slot itself
                    if (r_cmd == CMD_INSERT && r_i == r_j) begin
                        r_a <= r_val;
                        r_state <= S_WR;
                    end else if (r_cmd == CMD_SEARCH && r_lo > r_hi) begin
                        r_state <= S_DONE;
                    end else if (r_cmd == CMD_DELETE && r_i + 1'b1 >= r_cnt) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        if (r_cmd == CMD_INSERT) r_i <= r_i - 1'b1;
                        if (r_cmd == CMD_DELETE) r_i <= r_i + 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_USE;
                S_USE: begin
                    r_state <= S_RD;
                    unique case (r_cmd)
                        CMD_READ: begin r_res <= x; r_state <= S_DONE; end
                        CMD_PERFECT: begin
                            if (is_perfect(x)) r_res <= r_res + 1;
                            r_i <= r_i + 1'b1;
                            if (r_i + 1'b1 >= r_cnt) r_state <= S_DONE;
                        end
                        CMD_SECOND: begin
                            if (x > r_a) begin r_b <= r_a; r_a <= x; end
                            else if (x > r_b && x < r_a) r_b <= x;
                            r_i <= r_i + 1'b1;
                            if (r_i + 1'b1 >= r_cnt) begin
                                r_res <= (x > r_a) ? r_a
                                       : ((x > r_b && x < r_a) ? x : r_b);
                                r_state <= S_DONE;
                            end
                        end
                        CMD_SEARCH: begin
                            if (x == r_val) begin
                                r_found <= 1'b1;
                                r_state <= S_DONE;
                            end else if (x < r_val) r_lo <= (CW+1)'(mid + 1);
                            else r_hi <= (CW+1)'(mid - 1);
                        end
                        CMD_INSERT: begin
                            // r_i points at the source; step it up to the destination
                            r_i <= r_i + 1'b1;
                            r_a <= x;
                            r_state <= S_WR;
                        end
                        CMD_DELETE: begin
                            r_i <= r_i - 1'b1;
                            r_a <= x;
                            r_state <= S_WR;
                        end
                        CMD_PART: begin
                            if (x[0] == r_pass) r_w <= r_w + 1'b1;
                            r_i <= r_i + 1'b1;
                            if (r_i + 1'b1 >= r_cnt) begin
                                r_i <= '0;
                                // go through S_P2 so the first scratch read data is ready
                                if (r_pass) r_state <= S_P2;
                                else r_pass <= 1'b1;
                            end
                        end
                        CMD_REVERSE: begin
                            if (!r_half) begin
                                r_a <= x;
                                r_half <= 1'b1;
                            end else begin
                                r_b <= x;
                                r_state <= S_WR;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_WR: begin
                    r_state <= S_RD;
                    unique case (r_cmd)
                        CMD_APPEND: begin
                            r_cnt <= r_cnt + 1'b1;
                            r_state <= S_DONE;
                        end
                        CMD_INSERT: begin
                            if (r_i == r_j) begin
                                r_cnt <= r_cnt + 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_i <= r_i - 1'b1;
                            end
                        end
                        CMD_DELETE: r_i <= r_i + 1'b1;
                        CMD_REVERSE: begin
                            if (!r_half) begin
                                r_i <= r_i + 1'b1;
                                r_j <= r_j - 1'b1;
                                if (r_i + 1'b1 >= r_j - 1'b1) r_state <= S_DONE;
                            end else begin
                                r_half <= 1'b0;
                                r_state <= S_WR;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_P2: r_state <= S_COPY;
                S_COPY: begin
                    r_i <= r_i + 1'b1;
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (r_i >= r_cnt) r_state <= S_DONE;
                    else r_state <= S_COPY;
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    o_result.status <= r_st;
                    o_result.result_value <= r_res;
                    o_result.found <= r_found;
                    o_result.length <= POS_W'(r_cnt);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
